// ===== sv/button_press_classifier_with_timers_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Button press classifier - assertion macros
// Shared assertion helpers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_WITH_TIMERS_UNIT_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_WITH_TIMERS_UNIT_MACROS_SVH

// Same-cycle implication
`define BPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Button press classifier package
// Request and result types, command codes and constants shared by the classifier modules.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Request command codes
  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_START_BEEP = 3'd1,
    CMD_FETCH      = 3'd2,
    CMD_LOAD_SENS  = 3'd3,
    CMD_LOAD_SCRL  = 3'd4,
    CMD_LOAD_ALARM = 3'd5
  } cmd_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_SHORT_PRESS = 2'd0;
  localparam logic [1:0] CFG_LONG_PRESS  = 2'd1;
  localparam logic [1:0] CFG_TICKS_SEC   = 2'd2;

  // Register reset values
  localparam logic [15:0] SHORT_PRESS_RST = 16'd5;
  localparam logic [15:0] LONG_PRESS_RST  = 16'd50;
  localparam logic [7:0]  TICKS_SEC_RST   = 8'd100;

  // Beeper pattern gate
  localparam logic [7:0]  BEEP_MASK  = 8'h0E;
  localparam logic [7:0]  BEEP_LIMIT = 8'd8;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [15:0] short_press_ticks;
    logic [15:0] long_press_ticks;
    logic [7:0]  ticks_per_second;
  } cfg_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        key_set_n;
    logic        key_inc_n;
    logic        key_dec_n;
    logic [15:0] load_value;
  } item_t;

  typedef struct packed {
    logic [15:0] alarm_seconds;
    logic [7:0]  scroll_seconds;
    logic [7:0]  sensor_seconds;
    logic        beeper_level;
    logic [7:0]  button_command;
  } result_t;

  // Pipeline control between stages
  typedef struct packed {
    logic in_load;
    logic advance;
  } pipe_ctl_t;

endpackage

// ===== sv/bpc_cfg.sv =====
// ----------------------------------------------------------------------------
// Button press classifier configuration registers
// Holds the press thresholds and the prescaler reload value.
// ----------------------------------------------------------------------------
module bpc_cfg (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [1:0]   wr_index,
  input  logic [15:0]  wr_data,
  output bpc_pkg::cfg_t cfg
);
  import bpc_pkg::*;

  cfg_t cfg_r;

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_press_ticks <= SHORT_PRESS_RST;
      cfg_r.long_press_ticks  <= LONG_PRESS_RST;
      cfg_r.ticks_per_second  <= TICKS_SEC_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_SHORT_PRESS: cfg_r.short_press_ticks <= wr_data;
        CFG_LONG_PRESS:  cfg_r.long_press_ticks  <= wr_data;
        CFG_TICKS_SEC:   cfg_r.ticks_per_second  <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/bpc_in_stage.sv =====
// ----------------------------------------------------------------------------
// Button press classifier input register
// Captures one request; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module bpc_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  bpc_pkg::pipe_ctl_t ctl,
  input  bpc_pkg::item_t     item_in,
  output logic               valid,
  output bpc_pkg::item_t     item
);
  import bpc_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // Occupancy
  always_comb begin
    valid_nxt = valid_r;
    if (ctl.in_load) begin
      valid_nxt = 1'b1;
    end else if (ctl.advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ctl.in_load) begin
      item_r <= item_in;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

// ===== sv/bpc_core.sv =====
// ----------------------------------------------------------------------------
// Button press classifier core
// Key classification, second prescaler, countdowns and beeper pattern.
// ----------------------------------------------------------------------------
module bpc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  bpc_pkg::pipe_ctl_t ctl,
  input  bpc_pkg::cfg_t      cfg,
  input  bpc_pkg::item_t     item,
  output bpc_pkg::result_t   result
);
  import bpc_pkg::*;

  logic [15:0] press_count_r, press_count_nxt;
  logic [2:0]  held_keys_r, held_keys_nxt;
  logic [7:0]  pending_r, pending_nxt;
  logic [7:0]  prescaler_r, prescaler_nxt;
  logic [7:0]  sensor_r, sensor_nxt;
  logic [7:0]  scroll_r, scroll_nxt;
  logic [15:0] alarm_r, alarm_nxt;
  logic [7:0]  beep_cnt_r, beep_cnt_nxt;
  logic        beep_pin_r, beep_pin_nxt;

  logic [15:0] count_inc;
  logic [2:0]  key_mask;
  logic [7:0]  fetched;

  // Next state for one request
  always_comb begin
    press_count_nxt = press_count_r;
    held_keys_nxt   = held_keys_r;
    pending_nxt     = pending_r;
    prescaler_nxt   = prescaler_r;
    sensor_nxt      = sensor_r;
    scroll_nxt      = scroll_r;
    alarm_nxt       = alarm_r;
    beep_cnt_nxt    = beep_cnt_r;
    beep_pin_nxt    = beep_pin_r;
    fetched         = 8'd0;
    key_mask        = ~{item.key_dec_n, item.key_inc_n, item.key_set_n};
    count_inc       = (press_count_r == COUNT_MAX) ? press_count_r
                                                   : press_count_r + 16'd1;
    case (item.cmd)
      CMD_TICK: begin
        // Key classification
        if (key_mask != 3'd0) begin
          if (key_mask == held_keys_r) begin
            press_count_nxt = count_inc;
            if (count_inc == cfg.long_press_ticks) begin
              pending_nxt = {1'b0, held_keys_r, 4'd0};
            end
          end else begin
            held_keys_nxt = key_mask;
          end
        end else begin
          if ((press_count_r > cfg.short_press_ticks) &&
              (press_count_r < cfg.long_press_ticks)) begin
            pending_nxt = {5'd0, held_keys_r};
          end
          press_count_nxt = 16'd0;
        end
        // Second prescaler and countdowns
        if (prescaler_r != 8'd0) begin
          prescaler_nxt = prescaler_r - 8'd1;
        end else begin
          prescaler_nxt = cfg.ticks_per_second;
          if (sensor_r != 8'd0) sensor_nxt = sensor_r - 8'd1;
          if (scroll_r != 8'd0) scroll_nxt = scroll_r - 8'd1;
          if (alarm_r != 16'd0) alarm_nxt = alarm_r - 16'd1;
        end
        // Beep countdown reloads while the alarm runs
        if (beep_cnt_r != 8'd0) begin
          beep_cnt_nxt = beep_cnt_r - 8'd1;
        end else if (alarm_nxt != 16'd0) begin
          beep_cnt_nxt = cfg.ticks_per_second;
        end
        // Beeper pin pattern
        if ((beep_cnt_nxt & BEEP_MASK) > BEEP_LIMIT) begin
          if (prescaler_nxt > (cfg.ticks_per_second >> 1)) begin
            beep_pin_nxt = 1'b0;
          end
        end else begin
          beep_pin_nxt = 1'b1;
        end
      end
      CMD_START_BEEP: begin
        beep_cnt_nxt  = item.load_value[7:0];
        prescaler_nxt = cfg.ticks_per_second;
        alarm_nxt     = 16'd0;
      end
      CMD_FETCH: begin
        fetched     = pending_r;
        pending_nxt = 8'd0;
      end
      CMD_LOAD_SENS:  sensor_nxt = item.load_value[7:0];
      CMD_LOAD_SCRL:  scroll_nxt = item.load_value[7:0];
      CMD_LOAD_ALARM: alarm_nxt  = item.load_value;
      default: ;
    endcase
  end

  // State registers, updated as a request moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_count_r <= 16'd0;
      held_keys_r   <= 3'd0;
      pending_r     <= 8'd0;
      prescaler_r   <= TICKS_SEC_RST;
      sensor_r      <= 8'd0;
      scroll_r      <= 8'd0;
      alarm_r       <= 16'd0;
      beep_cnt_r    <= 8'd0;
      beep_pin_r    <= 1'b1;
    end else if (ctl.advance) begin
      press_count_r <= press_count_nxt;
      held_keys_r   <= held_keys_nxt;
      pending_r     <= pending_nxt;
      prescaler_r   <= prescaler_nxt;
      sensor_r      <= sensor_nxt;
      scroll_r      <= scroll_nxt;
      alarm_r       <= alarm_nxt;
      beep_cnt_r    <= beep_cnt_nxt;
      beep_pin_r    <= beep_pin_nxt;
    end
  end

  // Result reflects the updated state
  always_comb begin
    result.button_command = fetched;
    result.beeper_level   = beep_pin_nxt;
    result.sensor_seconds = sensor_nxt;
    result.scroll_seconds = scroll_nxt;
    result.alarm_seconds  = alarm_nxt;
  end

endmodule

// ===== sv/bpc_out_stage.sv =====
// ----------------------------------------------------------------------------
// Button press classifier result register
// Holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module bpc_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  bpc_pkg::pipe_ctl_t ctl,
  input  logic               out_taken,
  input  bpc_pkg::result_t   result_in,
  output logic               valid,
  output bpc_pkg::result_t   result
);
  import bpc_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  // Occupancy
  always_comb begin
    valid_nxt = valid_r;
    if (ctl.advance) begin
      valid_nxt = 1'b1;
    end else if (out_taken) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      result_r <= result_in;
    end
  end

  assign valid  = valid_r;
  assign result = result_r;

endmodule

// ===== sv/button_press_classifier_with_timers_unit.sv =====
// Sustains one request per clock while the output is not stalled: a request
// is captured in an input register, goes through the key, prescaler and
// beeper update and lands in the result register. The result register
// sets the throughput; a request moves on whenever that register is empty
// or being taken. Configuration writes are taken in any cycle and apply to
// requests processed after them; no clearing pass follows reset.
// ----------------------------------------------------------------------------
// Button press classifier with timers - top level
// Short/long key press detection, second countdowns and alarm beeper.
// ----------------------------------------------------------------------------
`include "button_press_classifier_with_timers_unit_macros.svh"

module button_press_classifier_with_timers_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // key_set_n, key_inc_n, key_dec_n, load_value[15:0], pad
  input  logic [2:0]  in_tuser,  // cmd
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata  // button_command[7:0], beeper_level,
                                 // sensor_seconds[7:0], scroll_seconds[7:0],
                                 // alarm_seconds[15:0], pad
);
  import bpc_pkg::*;

  cfg_t      cfg;
  item_t     item_in;
  item_t     item;
  result_t   result_comb;
  result_t   result;
  pipe_ctl_t ctl;
  logic      in_valid;

  // Request unpacking
  always_comb begin
    item_in.cmd        = cmd_t'(in_tuser);
    item_in.key_set_n  = in_tdata[0];
    item_in.key_inc_n  = in_tdata[1];
    item_in.key_dec_n  = in_tdata[2];
    item_in.load_value = in_tdata[18:3];
  end

  // Pipeline control
  assign ctl.advance = in_valid & (~out_tvalid | out_tready);
  assign in_tready   = ~in_valid | ctl.advance;
  assign ctl.in_load = in_tvalid & in_tready;
  assign cfg_ready   = 1'b1;

  bpc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bpc_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .item_in (item_in),
    .valid   (in_valid),
    .item    (item)
  );

  bpc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .cfg    (cfg),
    .item   (item),
    .result (result_comb)
  );

  bpc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .out_taken (out_tvalid & out_tready),
    .result_in (result_comb),
    .valid     (out_tvalid),
    .result    (result)
  );

  // Result packing
  assign out_tdata = {7'd0, result.alarm_seconds, result.scroll_seconds,
                      result.sensor_seconds, result.beeper_level,
                      result.button_command};

  // Checks
  `BPC_ASSERT_IMPL(a_drain_when_empty, !out_tvalid, in_tready,
                   "input stalled with an empty result register")
  `BPC_ASSERT_NEXT(a_advance_fills, ctl.advance, out_tvalid,
                   "advanced request did not reach the result register")
  `BPC_ASSERT_IMPL(a_one_press_kind, out_tvalid,
                   (result.button_command[7:4] == 4'd0) ||
                   (result.button_command[3:0] == 4'd0),
                   "command holds both a short and a long press")
  `BPC_ASSERT_IMPL(a_cmd_unused_bits, out_tvalid,
                   (result.button_command[7] == 1'b0) &&
                   (result.button_command[3] == 1'b0),
                   "command holds a key outside the mask")

endmodule
